// ----- rtl/assert_macros.svh -----
// assertion macros, included by plane_depth_sort_cell_core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while reset is asserted
`define PDSC_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("pdsc assertion failed");

// clocked check, also active during reset
`define PDSC_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("pdsc assertion failed");

`endif

// ----- rtl/pdsc_pkg.sv -----
// types and constants of the plane depth sort cell
package pdsc_pkg;

    localparam int TAG_WIDTH   = 16;
    localparam int DEPTH_WIDTH = 32;
    localparam int ID_WIDTH    = 16;
    localparam int MODE_WIDTH  = 2;
    localparam int OP_WIDTH    = 4;

    localparam int MODE_NOP_BIT   = 0;
    localparam int MODE_FLUSH_BIT = 1;

    typedef enum logic [OP_WIDTH-1:0] {
        OP_FORW_VISIB        = 4'd0,
        OP_FORW_VISIB_FP     = 4'd1,
        OP_FORW_INVIS        = 4'd2,
        OP_FORW_INVIS_FP     = 4'd3,
        OP_FORW_PERP         = 4'd4,
        OP_FORW_PERP_FP      = 4'd5,
        OP_REV_VISIB         = 4'd6,
        OP_REV_INVIS         = 4'd7,
        OP_REV_REPLACE_IF    = 4'd8,
        OP_TEST_SHAD_FORW    = 4'd9,
        OP_TEST_SHAD_FORW_FP = 4'd10,
        OP_TEST_SHAD_PERP    = 4'd11,
        OP_TEST_SHAD_PERP_FP = 4'd12,
        OP_TEST_SHADOW_REV   = 4'd13,
        OP_TEST_LIGHT_REV    = 4'd14,
        OP_BEGIN_TRANS       = 4'd15
    } op_t;

    typedef enum logic [2:0] {
        IL_NOP        = 3'd0,
        IL_LOAD       = 3'd1,
        IL_FURTHER    = 3'd2,
        IL_CLOSER     = 3'd3,
        IL_INVIS_FORW = 3'd4
    } il_t;

    typedef enum logic [1:0] {
        UL_NOP    = 2'd0,
        UL_LOAD   = 2'd1,
        UL_CLOSER = 2'd2
    } ul_t;

    typedef enum logic [1:0] {
        TS_NOP            = 2'd0,
        TS_CLOSER         = 2'd1,
        TS_SHADOW_FURTHER = 2'd2,
        TS_LIGHT_FURTHER  = 2'd3
    } ts_t;

    typedef enum logic [2:0] {
        PM_NONE      = 3'd0,
        PM_SHAD_FORW = 3'd1,
        PM_SHADOW    = 3'd2,
        PM_LIGHT     = 3'd3,
        PM_TRANS     = 3'd4,
        PM_DEF_REP   = 3'd5
    } pm_t;

    typedef struct packed {
        il_t  il;
        ul_t  ul;
        ts_t  ts;
        logic vis;
        logic clr;
        logic perp;
        logic mux;
    } ctl_t;

    typedef struct packed {
        logic                          shadow_flag;
        logic signed [DEPTH_WIDTH-1:0] nearest_depth;
        logic [ID_WIDTH-1:0]           nearest_id;
    } res_t;

endpackage

// ----- rtl/pdsc_if.sv -----
// request and result channels of the plane depth sort cell
interface pdsc_in_if;
    import pdsc_pkg::*;

    logic                          valid;
    logic                          ready;
    logic [MODE_WIDTH-1:0]         mode;
    logic [OP_WIDTH-1:0]           plane_op;
    logic                          second_object;
    logic signed [DEPTH_WIDTH-1:0] plane_depth;
    logic [ID_WIDTH-1:0]           plane_id;

    modport source (
        output valid, mode, plane_op, second_object, plane_depth, plane_id,
        input  ready
    );
    modport sink (
        input  valid, mode, plane_op, second_object, plane_depth, plane_id,
        output ready
    );
endinterface

interface pdsc_out_if;
    import pdsc_pkg::*;

    logic                          valid;
    logic                          ready;
    logic                          shadow_flag;
    logic signed [DEPTH_WIDTH-1:0] nearest_depth;
    logic [ID_WIDTH-1:0]           nearest_id;

    modport source (
        output valid, shadow_flag, nearest_depth, nearest_id,
        input  ready
    );
    modport sink (
        input  valid, shadow_flag, nearest_depth, nearest_id,
        output ready
    );
endinterface

// ----- rtl/plane_depth_sort_cell_core.sv -----
// top level of the plane depth sort cell: input register, cell update, result register
// One request per clock while results are taken: a request is first captured in
// the input register, and from there it is decoded, compared against the
// candidate depth and written into the cell state and the result register
// together. The input side keeps accepting while a result waits, as long as the
// input register is empty; both registers stall together while the result is
// not taken. Reset clears all cell state to zero.
module plane_depth_sort_cell_core (
    input  logic       clk,
    input  logic       rst_n,
    pdsc_in_if.sink    in_ch,
    pdsc_out_if.source out_ch
);
    import pdsc_pkg::*;

    `include "assert_macros.svh"

    logic                          s1_valid_reg;
    logic [MODE_WIDTH-1:0]         s1_mode_reg;
    logic [OP_WIDTH-1:0]           s1_op_reg;
    logic                          s1_second_reg;
    logic signed [DEPTH_WIDTH-1:0] s1_depth_reg;
    logic [ID_WIDTH-1:0]           s1_id_reg;

    logic                          out_valid_reg;
    res_t                          out_res_reg;

    logic                          adv, step;
    ctl_t                          ctl;
    logic                          pm_we;
    pm_t                           pm, pm_next;
    res_t                          res_next;

    assign adv         = !out_valid_reg || out_ch.ready;
    assign step        = s1_valid_reg && adv;
    assign in_ch.ready = !s1_valid_reg || adv;

    pdsc_decode u_decode (
        .mode          (s1_mode_reg),
        .plane_op      (s1_op_reg),
        .second_object (s1_second_reg),
        .pm            (pm),
        .ctl           (ctl),
        .pm_we         (pm_we),
        .pm_next       (pm_next)
    );

    pdsc_surf u_surf (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (step),
        .ctl      (ctl),
        .pm_we    (pm_we),
        .pm_next  (pm_next),
        .depth    (s1_depth_reg),
        .id       (s1_id_reg),
        .pm       (pm),
        .res_next (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ch.ready)
            begin
                s1_valid_reg <= in_ch.valid;
            end
            if (adv)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            s1_mode_reg   <= in_ch.mode;
            s1_op_reg     <= in_ch.plane_op;
            s1_second_reg <= in_ch.second_object;
            s1_depth_reg  <= in_ch.plane_depth;
            s1_id_reg     <= in_ch.plane_id;
        end
        if (step)
        begin
            out_res_reg <= res_next;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.shadow_flag   = out_res_reg.shadow_flag;
    assign out_ch.nearest_depth = out_res_reg.nearest_depth;
    assign out_ch.nearest_id    = out_res_reg.nearest_id;

    `PDSC_ASSERT(a_stall_blocks_input,
        (s1_valid_reg && out_valid_reg && !out_ch.ready) |-> !in_ch.ready)
    `PDSC_ASSERT(a_step_gives_result, step |=> out_valid_reg)
    `PDSC_ASSERT(a_result_has_source, $rose(out_valid_reg) |-> $past(s1_valid_reg))
    `PDSC_ASSERT_ALWAYS(a_reset_empty, !rst_n |-> (!s1_valid_reg && !out_valid_reg))

endmodule

// ----- rtl/pdsc_decode.sv -----
// opcode widening, nop and flush modes, and pending modifier override
module pdsc_decode (
    input  logic [pdsc_pkg::MODE_WIDTH-1:0] mode,
    input  logic [pdsc_pkg::OP_WIDTH-1:0]   plane_op,
    input  logic                            second_object,
    input  pdsc_pkg::pm_t                   pm,
    output pdsc_pkg::ctl_t                  ctl,
    output logic                            pm_we,
    output pdsc_pkg::pm_t                   pm_next
);
    import pdsc_pkg::*;

    function automatic ctl_t mk(il_t il, ul_t ul, logic vis, logic perp, logic mux);
        ctl_t c;
        c.il   = il;
        c.ul   = ul;
        c.ts   = TS_NOP;
        c.vis  = vis;
        c.clr  = 1'b0;
        c.perp = perp;
        c.mux  = mux;
        return c;
    endfunction

    ul_t  fpu;
    ctl_t base;
    pm_t  op_pm;

    assign fpu = second_object ? UL_LOAD : UL_CLOSER;

    always_comb
    begin
        op_pm = PM_NONE;
        case (plane_op)
            OP_FORW_VISIB:        base = mk(IL_FURTHER, UL_NOP, 1'b1, 1'b0, 1'b0);
            OP_FORW_VISIB_FP:     base = mk(IL_LOAD, fpu, 1'b1, 1'b0, 1'b1);
            OP_FORW_INVIS:        base = mk(IL_FURTHER, UL_NOP, 1'b0, 1'b0, 1'b0);
            OP_FORW_INVIS_FP:     base = mk(IL_LOAD, fpu, 1'b0, 1'b0, 1'b1);
            OP_FORW_PERP:         base = mk(IL_FURTHER, UL_NOP, 1'b0, 1'b1, 1'b0);
            OP_FORW_PERP_FP:      base = mk(IL_LOAD, fpu, 1'b1, 1'b1, 1'b1);
            OP_REV_VISIB:         base = mk(IL_CLOSER, UL_NOP, 1'b1, 1'b0, 1'b0);
            OP_REV_INVIS:         base = mk(IL_CLOSER, UL_NOP, 1'b0, 1'b0, 1'b0);
            OP_REV_REPLACE_IF:
            begin
                op_pm = PM_DEF_REP;
                base  = mk(IL_CLOSER, UL_NOP, 1'b0, 1'b0, 1'b0);
            end
            OP_TEST_SHAD_FORW:
            begin
                op_pm = PM_SHAD_FORW;
                base  = mk(IL_FURTHER, UL_NOP, 1'b1, 1'b0, 1'b0);
            end
            OP_TEST_SHAD_FORW_FP:
            begin
                op_pm = PM_SHAD_FORW;
                base  = mk(IL_LOAD, fpu, 1'b1, 1'b0, 1'b1);
            end
            OP_TEST_SHAD_PERP:
            begin
                op_pm = PM_SHAD_FORW;
                base  = mk(IL_FURTHER, UL_NOP, 1'b0, 1'b1, 1'b0);
            end
            OP_TEST_SHAD_PERP_FP:
            begin
                op_pm = PM_SHAD_FORW;
                base  = mk(IL_LOAD, fpu, 1'b0, 1'b1, 1'b1);
            end
            OP_TEST_SHADOW_REV:
            begin
                op_pm = PM_SHADOW;
                base  = mk(IL_CLOSER, UL_NOP, 1'b0, 1'b0, 1'b0);
            end
            OP_TEST_LIGHT_REV:
            begin
                op_pm = PM_LIGHT;
                base  = mk(IL_CLOSER, UL_NOP, 1'b0, 1'b0, 1'b0);
            end
            default:
            begin
                op_pm = PM_TRANS;
                base  = mk(IL_NOP, UL_CLOSER, 1'b1, 1'b0, 1'b1);
            end
        endcase
    end

    always_comb
    begin
        pm_we   = 1'b0;
        pm_next = op_pm;
        ctl     = base;
        if (mode[MODE_NOP_BIT])
        begin
            ctl = mk(IL_NOP, UL_NOP, 1'b0, 1'b0, 1'b0);
        end
        else if (mode[MODE_FLUSH_BIT])
        begin
            // flush offers the candidate to held through UL_CLOSER
            ctl = mk(IL_NOP, UL_CLOSER, 1'b1, 1'b0, 1'b1);
        end
        else
        begin
            pm_we = 1'b1;
            case (pm)
                PM_SHAD_FORW:
                begin
                    ctl.ts  = TS_CLOSER;
                    ctl.il  = IL_LOAD;
                    ctl.mux = 1'b1;
                end
                PM_SHADOW:
                begin
                    ctl.ts = TS_SHADOW_FURTHER;
                    ctl.ul = UL_NOP;
                end
                PM_LIGHT:
                begin
                    ctl.ts = TS_LIGHT_FURTHER;
                    ctl.ul = UL_NOP;
                end
                PM_TRANS:
                begin
                    ctl.clr = 1'b1;
                    ctl.ul  = UL_NOP;
                end
                PM_DEF_REP:
                begin
                    ctl.il = IL_INVIS_FORW;
                end
                default:
                begin
                    ctl = base;
                end
            endcase
        end
    end

endmodule

// ----- rtl/pdsc_surf.sv -----
// candidate and held registers with depth compare and shadow update
module pdsc_surf (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   en,
    input  pdsc_pkg::ctl_t                         ctl,
    input  logic                                   pm_we,
    input  pdsc_pkg::pm_t                          pm_next,
    input  logic signed [pdsc_pkg::DEPTH_WIDTH-1:0] depth,
    input  logic [pdsc_pkg::ID_WIDTH-1:0]          id,
    output pdsc_pkg::pm_t                          pm,
    output pdsc_pkg::res_t                         res_next
);
    import pdsc_pkg::*;

    logic signed [DEPTH_WIDTH-1:0] cand_depth_reg, cand_depth_next;
    logic [TAG_WIDTH-1:0]          cand_tag_reg, cand_tag_next;
    logic                          cand_visible_reg, cand_visible_next;
    logic                          cand_forward_reg, cand_forward_next;
    logic signed [DEPTH_WIDTH-1:0] held_depth_reg, held_depth_next;
    logic [TAG_WIDTH-1:0]          held_tag_reg, held_tag_next;
    logic                          held_visible_reg, held_visible_next;
    logic                          held_shadow_reg, held_shadow_next;
    logic                          shadow_scratch_reg, shadow_scratch_next;
    pm_t                           pm_reg;

    logic signed [DEPTH_WIDTH-1:0] cmp_depth;
    logic                          gte, lte, i_re, u_re;
    logic [63:0]                   id_wide, tag_wide;
    logic [TAG_WIDTH-1:0]          tag_in;

    assign cmp_depth = ctl.mux ? held_depth_reg : depth;
    assign gte       = cand_depth_reg >= cmp_depth;
    assign lte       = cand_depth_reg <= cmp_depth;

    assign id_wide = {{(64-ID_WIDTH){1'b0}}, id};
    assign tag_in  = id_wide[TAG_WIDTH-1:0];

    always_comb
    begin
        i_re              = 1'b0;
        cand_visible_next = cand_visible_reg;
        cand_forward_next = cand_forward_reg;
        case (ctl.il)
            IL_LOAD:
            begin
                i_re              = 1'b1;
                cand_forward_next = 1'b1;
                cand_visible_next = ctl.vis;
            end
            IL_FURTHER:
            begin
                // perpendicular planes load on a negative depth
                if ((!ctl.perp && gte) || (ctl.perp && depth[DEPTH_WIDTH-1]))
                begin
                    i_re              = 1'b1;
                    cand_forward_next = 1'b1;
                    cand_visible_next = ctl.vis;
                end
            end
            IL_CLOSER:
            begin
                if (!gte)
                begin
                    i_re              = 1'b1;
                    cand_forward_next = 1'b0;
                    cand_visible_next = ctl.vis;
                end
            end
            IL_INVIS_FORW:
            begin
                if (!cand_visible_reg && cand_forward_reg)
                begin
                    i_re              = 1'b1;
                    cand_forward_next = 1'b0;
                    cand_visible_next = ctl.vis;
                end
            end
            default:
            begin
                i_re = 1'b0;
            end
        endcase
        cand_depth_next = i_re ? depth : cand_depth_reg;
        cand_tag_next   = i_re ? tag_in : cand_tag_reg;
    end

    always_comb
    begin
        u_re = (ctl.ul == UL_LOAD) ||
               ((ctl.ul == UL_CLOSER) && ((gte && cand_visible_reg) || !held_visible_reg));
        held_visible_next   = u_re ? cand_visible_reg : held_visible_reg;
        held_shadow_next    = held_shadow_reg;
        shadow_scratch_next = 1'b0;
        if (u_re)
        begin
            held_shadow_next = 1'b0;
        end
        else
        begin
            case (ctl.ts)
                TS_CLOSER:
                begin
                    shadow_scratch_next = !lte;
                end
                TS_SHADOW_FURTHER:
                begin
                    held_shadow_next    = held_shadow_reg || (lte && shadow_scratch_reg);
                    shadow_scratch_next = shadow_scratch_reg;
                end
                TS_LIGHT_FURTHER:
                begin
                    held_shadow_next    = !((lte && shadow_scratch_reg) || !held_shadow_reg);
                    shadow_scratch_next = shadow_scratch_reg;
                end
                default:
                begin
                    shadow_scratch_next = shadow_scratch_reg;
                end
            endcase
        end
        held_depth_next = u_re ? cand_depth_reg : held_depth_reg;
        if (u_re)
        begin
            held_tag_next = cand_tag_reg;
        end
        else if (ctl.clr)
        begin
            held_tag_next = '0;
        end
        else
        begin
            held_tag_next = held_tag_reg;
        end
    end

    assign tag_wide = {{(64-TAG_WIDTH){1'b0}}, held_tag_next};

    assign res_next.shadow_flag   = held_shadow_next;
    assign res_next.nearest_depth = held_depth_next;
    assign res_next.nearest_id    = tag_wide[ID_WIDTH-1:0];
    assign pm                     = pm_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cand_depth_reg     <= '0;
            cand_tag_reg       <= '0;
            cand_visible_reg   <= 1'b0;
            cand_forward_reg   <= 1'b0;
            held_depth_reg     <= '0;
            held_tag_reg       <= '0;
            held_visible_reg   <= 1'b0;
            held_shadow_reg    <= 1'b0;
            shadow_scratch_reg <= 1'b0;
            pm_reg             <= PM_NONE;
        end
        else if (en)
        begin
            cand_depth_reg     <= cand_depth_next;
            cand_tag_reg       <= cand_tag_next;
            cand_visible_reg   <= cand_visible_next;
            cand_forward_reg   <= cand_forward_next;
            held_depth_reg     <= held_depth_next;
            held_tag_reg       <= held_tag_next;
            held_visible_reg   <= held_visible_next;
            held_shadow_reg    <= held_shadow_next;
            shadow_scratch_reg <= shadow_scratch_next;
            if (pm_we)
            begin
                pm_reg <= pm_next;
            end
        end
    end

endmodule

// ----- test/tb_plane_depth_sort_cell_core.sv -----
// testbench of plane_depth_sort_cell_core: directed table then random requests checked by a predictor
module tb_plane_depth_sort_cell_core;
    import pdsc_pkg::*;

    localparam logic [MODE_WIDTH-1:0] MODE_PLANE = 2'd0;
    localparam logic [MODE_WIDTH-1:0] MODE_NOP   = 2'd1;
    localparam logic [MODE_WIDTH-1:0] MODE_FLUSH = 2'd2;
    localparam logic [MODE_WIDTH-1:0] MODE_BOTH  = 2'd3;
    localparam int N_SCRIPT    = 26;
    localparam int N_RANDOM    = 400;
    localparam int SETTLE_CYCLES = 10;

    typedef struct {
        logic [MODE_WIDTH-1:0]         mode;
        op_t                           op;
        logic                          sec;
        logic signed [DEPTH_WIDTH-1:0] depth;
        logic [ID_WIDTH-1:0]           id;
        logic                          pinned;
        res_t                          want;
    } plane_req_t;

    logic clk = 1'b0;
    logic rst_n;

    pdsc_in_if  in_ch ();
    pdsc_out_if out_ch ();

    plane_depth_sort_cell_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // predictor state: candidate (I) and held (U) registers
    logic signed [DEPTH_WIDTH-1:0] i_depth = '0;
    logic [TAG_WIDTH-1:0]          i_tag = '0;
    logic                          i_vis = 1'b0;
    logic                          i_fwd = 1'b0;
    logic signed [DEPTH_WIDTH-1:0] u_depth = '0;
    logic [TAG_WIDTH-1:0]          u_tag = '0;
    logic                          u_vis = 1'b0;
    logic                          u_shad = 1'b0;
    logic                          shad_tmp = 1'b0;
    pm_t                           pend = PM_NONE;

    plane_req_t req_q[$];
    res_t       nearest_q[$];
    bit         failed = 1'b0;
    int         burst_left = 0;
    int         ready_left = 0;
    int         ready_kind = 0;
    logic signed [DEPTH_WIDTH-1:0] last_depth = '0;

    plane_req_t script [N_SCRIPT] = '{
        '{MODE_NOP,   OP_FORW_VISIB,        1'b0, 32'sd0,           16'h0000, 1'b1,
          '{1'b0, 32'sd0, 16'h0000}},
        '{MODE_FLUSH, OP_BEGIN_TRANS,       1'b1, 32'sd77,          16'hffff, 1'b1,
          '{1'b0, 32'sd0, 16'h0000}},
        '{MODE_BOTH,  OP_TEST_SHAD_FORW,    1'b1, -32'sd1,          16'haaaa, 1'b1,
          '{1'b0, 32'sd0, 16'h0000}},
        '{MODE_PLANE, OP_FORW_VISIB_FP,     1'b1, 32'sh7fffffff,    16'hffff, 1'b1,
          '{1'b0, 32'sd0, 16'h0000}},
        '{MODE_FLUSH, OP_FORW_VISIB,        1'b0, 32'sd0,           16'h5555, 1'b1,
          '{1'b0, 32'sh7fffffff, 16'hffff}},
        '{MODE_PLANE, OP_FORW_VISIB,        1'b0, 32'sh80000000,    16'h0000, 1'b0, '0},
        '{MODE_PLANE, OP_FORW_INVIS,        1'b0, 32'sd0,           16'h1234, 1'b0, '0},
        '{MODE_PLANE, OP_FORW_INVIS_FP,     1'b0, -32'sd5,          16'h8001, 1'b0, '0},
        '{MODE_PLANE, OP_FORW_PERP,         1'b0, -32'sd1,          16'h00ff, 1'b0, '0},
        '{MODE_PLANE, OP_FORW_PERP_FP,      1'b1, 32'sd100,         16'h5a5a, 1'b0, '0},
        '{MODE_PLANE, OP_REV_VISIB,         1'b0, -32'sd100,        16'h0f0f, 1'b0, '0},
        '{MODE_PLANE, OP_REV_REPLACE_IF,    1'b0, 32'sd300,         16'h7777, 1'b0, '0},
        '{MODE_PLANE, OP_FORW_VISIB,        1'b1, 32'sd50,          16'h0042, 1'b0, '0},
        '{MODE_PLANE, OP_TEST_SHAD_FORW,    1'b0, 32'sd10,          16'h0101, 1'b0, '0},
        '{MODE_PLANE, OP_FORW_VISIB_FP,     1'b1, 32'sd20,          16'h0202, 1'b0, '0},
        '{MODE_PLANE, OP_TEST_SHAD_FORW_FP, 1'b1, 32'sd20,          16'h0303, 1'b0, '0},
        '{MODE_PLANE, OP_TEST_SHAD_PERP,    1'b0, -32'sd7,          16'h0404, 1'b0, '0},
        '{MODE_PLANE, OP_TEST_SHAD_PERP_FP, 1'b0, 32'sd7,           16'h0505, 1'b0, '0},
        '{MODE_PLANE, OP_TEST_SHADOW_REV,   1'b0, 32'sd0,           16'h0606, 1'b0, '0},
        '{MODE_PLANE, OP_REV_VISIB,         1'b0, 32'sd0,           16'h0707, 1'b0, '0},
        '{MODE_PLANE, OP_TEST_LIGHT_REV,    1'b0, 32'sh80000000,    16'h0808, 1'b0, '0},
        '{MODE_PLANE, OP_REV_INVIS,         1'b0, 32'sh7fffffff,    16'h0909, 1'b0, '0},
        '{MODE_PLANE, OP_BEGIN_TRANS,       1'b1, -32'sd3,          16'hc3c3, 1'b0, '0},
        '{MODE_NOP,   OP_FORW_VISIB,        1'b0, 32'sd0,           16'h0000, 1'b0, '0},
        '{MODE_PLANE, OP_FORW_INVIS_FP,     1'b0, 32'sd9,           16'h3c3c, 1'b0, '0},
        '{MODE_FLUSH, OP_REV_VISIB,         1'b0, 32'sd1,           16'h1111, 1'b0, '0}
    };

    function automatic ctl_t make_ctl(il_t il, ul_t ul, logic vis, logic perp, logic mux);
        ctl_t c;
        c.il   = il;
        c.ul   = ul;
        c.ts   = TS_NOP;
        c.vis  = vis;
        c.clr  = 1'b0;
        c.perp = perp;
        c.mux  = mux;
        return c;
    endfunction

    function automatic ctl_t widen_op(input op_t op, input logic sec, output pm_t nxt);
        ul_t fpu;
        fpu = sec ? UL_LOAD : UL_CLOSER;
        nxt = PM_NONE;
        case (op)
            OP_FORW_VISIB:        return make_ctl(IL_FURTHER, UL_NOP, 1'b1, 1'b0, 1'b0);
            OP_FORW_VISIB_FP:     return make_ctl(IL_LOAD, fpu, 1'b1, 1'b0, 1'b1);
            OP_FORW_INVIS:        return make_ctl(IL_FURTHER, UL_NOP, 1'b0, 1'b0, 1'b0);
            OP_FORW_INVIS_FP:     return make_ctl(IL_LOAD, fpu, 1'b0, 1'b0, 1'b1);
            OP_FORW_PERP:         return make_ctl(IL_FURTHER, UL_NOP, 1'b0, 1'b1, 1'b0);
            OP_FORW_PERP_FP:      return make_ctl(IL_LOAD, fpu, 1'b1, 1'b1, 1'b1);
            OP_REV_VISIB:         return make_ctl(IL_CLOSER, UL_NOP, 1'b1, 1'b0, 1'b0);
            OP_REV_INVIS:         return make_ctl(IL_CLOSER, UL_NOP, 1'b0, 1'b0, 1'b0);
            OP_REV_REPLACE_IF:
            begin
                nxt = PM_DEF_REP;
                return make_ctl(IL_CLOSER, UL_NOP, 1'b0, 1'b0, 1'b0);
            end
            OP_TEST_SHAD_FORW:
            begin
                nxt = PM_SHAD_FORW;
                return make_ctl(IL_FURTHER, UL_NOP, 1'b1, 1'b0, 1'b0);
            end
            OP_TEST_SHAD_FORW_FP:
            begin
                nxt = PM_SHAD_FORW;
                return make_ctl(IL_LOAD, fpu, 1'b1, 1'b0, 1'b1);
            end
            OP_TEST_SHAD_PERP:
            begin
                nxt = PM_SHAD_FORW;
                return make_ctl(IL_FURTHER, UL_NOP, 1'b0, 1'b1, 1'b0);
            end
            OP_TEST_SHAD_PERP_FP:
            begin
                nxt = PM_SHAD_FORW;
                return make_ctl(IL_LOAD, fpu, 1'b0, 1'b1, 1'b1);
            end
            OP_TEST_SHADOW_REV:
            begin
                nxt = PM_SHADOW;
                return make_ctl(IL_CLOSER, UL_NOP, 1'b0, 1'b0, 1'b0);
            end
            OP_TEST_LIGHT_REV:
            begin
                nxt = PM_LIGHT;
                return make_ctl(IL_CLOSER, UL_NOP, 1'b0, 1'b0, 1'b0);
            end
            default:
            begin
                nxt = PM_TRANS;
                return make_ctl(IL_NOP, UL_CLOSER, 1'b1, 1'b0, 1'b1);
            end
        endcase
    endfunction

    task automatic depth_sort_step(
        input  logic [MODE_WIDTH-1:0]         mode,
        input  op_t                           op,
        input  logic                          sec,
        input  logic signed [DEPTH_WIDTH-1:0] depth,
        input  logic [ID_WIDTH-1:0]           id,
        output res_t                          r
    );
        ctl_t c;
        pm_t nxt;
        logic signed [DEPTH_WIDTH-1:0] against;
        logic gte, lte, i_load, u_load, tmp, n_i_vis, n_i_fwd, n_u_vis, n_u_shad;
        if (mode[MODE_NOP_BIT])
            c = make_ctl(IL_NOP, UL_NOP, 1'b0, 1'b0, 1'b0);
        else if (mode[MODE_FLUSH_BIT])
            c = make_ctl(IL_NOP, UL_CLOSER, 1'b1, 1'b0, 1'b1);
        else
        begin
            c = widen_op(op, sec, nxt);
            case (pend)
                PM_SHAD_FORW:
                begin
                    c.ts  = TS_CLOSER;
                    c.il  = IL_LOAD;
                    c.mux = 1'b1;
                end
                PM_SHADOW:
                begin
                    c.ts = TS_SHADOW_FURTHER;
                    c.ul = UL_NOP;
                end
                PM_LIGHT:
                begin
                    c.ts = TS_LIGHT_FURTHER;
                    c.ul = UL_NOP;
                end
                PM_TRANS:
                begin
                    c.clr = 1'b1;
                    c.ul  = UL_NOP;
                end
                PM_DEF_REP:
                    c.il = IL_INVIS_FORW;
                default:
                    ;
            endcase
            pend = nxt;
        end

        against  = c.mux ? u_depth : depth;
        gte      = i_depth >= against;
        lte      = i_depth <= against;
        i_load   = 1'b0;
        n_i_vis  = i_vis;
        n_i_fwd  = i_fwd;
        n_u_vis  = u_vis;
        n_u_shad = u_shad;
        tmp      = 1'b0;

        if (c.clr)
            u_tag = '0;

        case (c.il)
            IL_LOAD:       i_load = 1'b1;
            IL_FURTHER:    i_load = c.perp ? depth[DEPTH_WIDTH-1] : gte;
            IL_CLOSER:     i_load = !gte;
            IL_INVIS_FORW: i_load = !i_vis && i_fwd;
            default:       i_load = 1'b0;
        endcase
        if (i_load)
        begin
            n_i_fwd = (c.il == IL_LOAD) || (c.il == IL_FURTHER);
            n_i_vis = c.vis;
        end

        u_load = (c.ul == UL_LOAD) || (c.ul == UL_CLOSER && ((gte && i_vis) || !u_vis));
        if (u_load)
        begin
            n_u_vis  = i_vis;
            n_u_shad = 1'b0;
        end
        else
        begin
            case (c.ts)
                TS_CLOSER:
                    tmp = !lte;
                TS_SHADOW_FURTHER:
                begin
                    n_u_shad = u_shad || (lte && shad_tmp);
                    tmp = shad_tmp;
                end
                TS_LIGHT_FURTHER:
                begin
                    n_u_shad = !((lte && shad_tmp) || !u_shad);
                    tmp = shad_tmp;
                end
                default:
                    tmp = shad_tmp;
            endcase
        end

        u_vis  = n_u_vis;
        u_shad = n_u_shad;
        if (u_load)
        begin
            u_depth = i_depth;
            u_tag   = i_tag;
        end
        i_vis    = n_i_vis;
        i_fwd    = n_i_fwd;
        shad_tmp = tmp;
        if (i_load)
        begin
            i_depth = depth;
            i_tag   = TAG_WIDTH'(id);
        end

        r.shadow_flag   = u_shad;
        r.nearest_depth = u_depth;
        r.nearest_id    = ID_WIDTH'(u_tag);
    endtask

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_req(input plane_req_t q);
        if (burst_left == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
        end
        burst_left--;
        req_q.push_back(q);
        in_ch.valid         <= 1'b1;
        in_ch.mode          <= q.mode;
        in_ch.plane_op      <= q.op;
        in_ch.second_object <= q.sec;
        in_ch.plane_depth   <= q.depth;
        in_ch.plane_id      <= q.id;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic wait_all_nearest();
        in_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (nearest_q.size() != 0);
    endtask

    // receiver stall pattern
    always @(negedge clk)
    begin
        if (ready_left == 0)
        begin
            ready_kind = $urandom_range(0, 2);
            ready_left = (ready_kind == 2) ? $urandom_range(1, 8) : $urandom_range(4, 30);
        end
        ready_left--;
        case (ready_kind)
            0:       out_ch.ready <= 1'b1;
            1:       out_ch.ready <= ($urandom_range(0, 3) != 0);
            default: out_ch.ready <= 1'b0;
        endcase
    end

    always @(posedge clk)
    begin : monitor
        plane_req_t req;
        res_t calc;
        res_t want;
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                req = req_q.pop_front();
                depth_sort_step(in_ch.mode, op_t'(in_ch.plane_op), in_ch.second_object,
                                in_ch.plane_depth, in_ch.plane_id, calc);
                nearest_q.push_back(req.pinned ? req.want : calc);
            end
            if (out_ch.valid && out_ch.ready)
            begin
                if (nearest_q.size() == 0)
                begin
                    $error("result with no request outstanding");
                    failed = 1'b1;
                end
                else
                begin
                    want = nearest_q.pop_front();
                    if (out_ch.shadow_flag !== want.shadow_flag)
                    begin
                        $error("shadow_flag: expected %0d, got %0d",
                               want.shadow_flag, out_ch.shadow_flag);
                        failed = 1'b1;
                    end
                    if (out_ch.nearest_depth !== want.nearest_depth)
                    begin
                        $error("nearest_depth: expected %0d, got %0d",
                               want.nearest_depth, out_ch.nearest_depth);
                        failed = 1'b1;
                    end
                    if (out_ch.nearest_id !== want.nearest_id)
                    begin
                        $error("nearest_id: expected 0x%04h, got 0x%04h",
                               want.nearest_id, out_ch.nearest_id);
                        failed = 1'b1;
                    end
                end
            end
        end
    end

    initial
    begin
        #200000;
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        plane_req_t r;
        int sel;
        rst_n               <= 1'b0;
        in_ch.valid         <= 1'b0;
        in_ch.mode          <= MODE_NOP;
        in_ch.plane_op      <= OP_FORW_VISIB;
        in_ch.second_object <= 1'b0;
        in_ch.plane_depth   <= '0;
        in_ch.plane_id      <= '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < N_SCRIPT; i++)
            send_req(script[i]);
        wait_all_nearest();

        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i == N_RANDOM / 2)
                wait_all_nearest();
            sel = $urandom_range(0, 99);
            if (sel < 6)
                r.mode = MODE_NOP;
            else if (sel < 9)
                r.mode = MODE_BOTH;
            else if (sel < 16)
                r.mode = MODE_FLUSH;
            else
                r.mode = MODE_PLANE;
            // modifier-setting opcodes often, so the next plane sees a pending modifier
            r.op = op_t'(4'(($urandom_range(0, 99) < 40) ? $urandom_range(8, 15)
                                                         : $urandom_range(0, 7)));
            r.sec = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 9))
                0, 1:
                    case ($urandom_range(0, 3))
                        0:       r.depth = 32'sh80000000;
                        1:       r.depth = 32'sh7fffffff;
                        2:       r.depth = 32'sd0;
                        default: r.depth = -32'sd1;
                    endcase
                2, 3, 4: r.depth = $signed(32'($urandom_range(0, 16))) - 32'sd8;
                5, 6:    r.depth = last_depth;
                default: r.depth = $signed($urandom);
            endcase
            last_depth = r.depth;
            r.id     = 16'($urandom);
            r.pinned = 1'b0;
            r.want   = '0;
            send_req(r);
        end

        in_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (nearest_q.size() != 0 || req_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (!failed && nearest_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/pdsc_pkg.sv
rtl/pdsc_if.sv
rtl/pdsc_decode.sv
rtl/pdsc_surf.sv
rtl/plane_depth_sort_cell_core.sv
test/tb_plane_depth_sort_cell_core.sv
